/* design/lruk_pkg.sv */
// Shared constants, types and helper functions for the LRU-K frame replacer.
`timescale 1ns / 1ps
package lruk_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int MAX_K      = 4;
  localparam int STAMP_BITS = 32;

  localparam int ID_W    = $clog2(NUM_FRAMES);
  localparam int SLOT_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CNT_W   = $clog2(MAX_K + 1);
  localparam int EVC_W   = $clog2(NUM_FRAMES + 1);
  localparam int SCAN_W  = $clog2(NUM_FRAMES + 2);
  localparam int NFR_W   = 7;
  localparam int DEPTH_W = 3;
  localparam int LIM_W   = (ID_W + 1 > NFR_W) ? ID_W + 1 : NFR_W;

  localparam int STAMP_AW    = ID_W + SLOT_W;
  localparam int STAMP_DEPTH = NUM_FRAMES * (2 ** SLOT_W);

  localparam logic [NFR_W-1:0]      NFR_RESET   = NFR_W'(64);
  localparam logic [DEPTH_W-1:0]    DEPTH_RESET = DEPTH_W'(2);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX   = {STAMP_BITS{1'b1}};

  // APB: one 32-bit register every 4 bytes, index taken from paddr[2]
  localparam int  PADDR_W  = 3;
  localparam int  PDATA_W  = 32;
  localparam logic CFG_NUM_FRAMES = 1'b0;
  localparam logic CFG_HIST_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    REQ_ACCESS   = 2'd0,
    REQ_SET_MARK = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_EVICT    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_PINNED = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  // Per-frame history bookkeeping: number of stamps held and next write slot
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] head;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [EVC_W-1:0] total;
    logic [ID_W-1:0]  vframe;
    logic             vvalid;
    status_e          status;
  } result_t;

  localparam int RES_W = $bits(result_t);
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;
  localparam int IN_W  = (((ID_W + 1) + 7) / 8) * 8;
  localparam int REQ_W = 2;

  // Slot holding the n-th latest stamp (n from 1) behind write slot head
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] head,
                                                  input logic [CNT_W-1:0]  n);
    logic [SLOT_W+1:0] sum;
    sum = (SLOT_W + 2)'(head) + (SLOT_W + 2)'(MAX_K) - (SLOT_W + 2)'(n);
    if (sum >= (SLOT_W + 2)'(MAX_K)) begin
      sum = sum - (SLOT_W + 2)'(MAX_K);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Clamp the history depth register into 1..MAX_K
  function automatic logic [CNT_W-1:0] k_eff(input logic [DEPTH_W-1:0] d);
    logic [CNT_W-1:0] k;
    if (d == '0) begin
      k = CNT_W'(1);
    end else if (int'(d) > MAX_K) begin
      k = CNT_W'(MAX_K);
    end else begin
      k = CNT_W'(d);
    end
    return k;
  endfunction

endpackage

/* design/lru_k_frame_replacer.sv */
// LRU-K victim selector: top level with request sequencer and victim scan.
//
// Requests enter on the s_axis channel (tuser = request kind, tdata = frame
// number and evictable mark); one result word per request leaves on m_axis.
// The APB port holds the frame limit (0x0) and history_depth (0x4); write it
// only while no request is in flight.
// Access, set-mark and remove requests are resolved in the exec state, once
// the output register is free. An evict request walks every frame through
// one shared compare and subtract unit, one frame a cycle, behind the two
// read stages of the per-frame bookkeeping RAM and the timestamp RAM, and
// then resolves in the victim state, once the output register is free.
// One request is worked at a time;
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; the next request is accepted while
// it waits, and a finished request holds until the receiver takes the word.
// Reset clears all frame marks, the history counts (through the present
// bits), the timestamp and the evictable count; the history RAMs need no
// clearing pass, since an untracked frame restarts its history at slot 0.
`timescale 1ns / 1ps
module lru_k_frame_replacer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lruk_pkg::IN_W-1:0]     s_axis_tdata,  // frame number, evictable mark, zero pad
  input  logic [lruk_pkg::REQ_W-1:0]    s_axis_tuser,  // req_type
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lruk_pkg::OUT_W-1:0]    m_axis_tdata,  // status, victim_valid,
                                                       // victim_frame, evictable_total
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lruk_pkg::PADDR_W-1:0]  paddr,
  input  logic [lruk_pkg::PDATA_W-1:0]  pwdata,
  output logic [lruk_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import lruk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_VICT
  } state_e;

  state_e                 state_q, state_d;
  req_e                   req_q, req_d;
  logic [ID_W-1:0]        frame_q, frame_d;
  logic                   mark_q, mark_d;
  logic [NUM_FRAMES-1:0]  present_q, present_d;
  logic [NUM_FRAMES-1:0]  evict_q, evict_d;
  logic [EVC_W-1:0]       evc_q, evc_d;
  logic [STAMP_BITS-1:0]  now_q, now_d;
  logic [NFR_W-1:0]       nfr_q, nfr_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;
  logic [SCAN_W-1:0]      scan_q, scan_d;
  logic                   v1_q, v1_d;
  logic [ID_W-1:0]        idx1_q, idx1_d;
  logic                   elig2_q, elig2_d;
  logic                   inf2_q, inf2_d;
  logic [ID_W-1:0]        idx2_q, idx2_d;
  logic                   found_q, found_d;
  logic                   binf_q, binf_d;
  logic [STAMP_BITS-1:0]  bkey_q, bkey_d;
  logic [ID_W-1:0]        best_q, best_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   cfg_write;
  logic [ID_W-1:0]        in_frame;
  logic                   id_ok;
  logic [CNT_W-1:0]       k;

  logic [ID_W-1:0]        meta_raddr;
  meta_t                  meta_rd;
  meta_t                  meta_wr;
  logic                   hist_we;
  logic [STAMP_AW-1:0]    stamp_raddr;
  logic [STAMP_BITS-1:0]  stamp_rd;

  logic [CNT_W-1:0]       cnt1;
  logic                   inf1;
  logic [SLOT_W-1:0]      slot1;
  logic [CNT_W-1:0]       cnt_old;
  logic [SLOT_W-1:0]      head_old;
  logic [STAMP_BITS-1:0]  key2;
  logic                   take2;
  result_t                res;

  assign in_frame      = s_axis_tdata[ID_W-1:0];
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[PADDR_W-1] == CFG_HIST_DEPTH) ? PDATA_W'(depth_q)
                                                           : PDATA_W'(nfr_q);

  assign id_ok = LIM_W'(frame_q) < LIM_W'(nfr_q);
  assign k     = k_eff(depth_q);

  // Bookkeeping RAM read port: scan index, held request, or incoming frame
  always_comb begin
    unique case (state_q)
      S_SCAN:  meta_raddr = scan_q[ID_W-1:0];
      S_EXEC:  meta_raddr = frame_q;
      default: meta_raddr = in_frame;
    endcase
  end

  lruk_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_FRAMES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (frame_q),
    .wdata_i (meta_wr),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rd)
  );

  // Scan stage 1: pick the stamp slot that sets this frame's key
  assign cnt1        = present_q[idx1_q] ? meta_rd.cnt : '0;
  assign inf1        = cnt1 < k;
  assign slot1       = slot_back(meta_rd.head, inf1 ? cnt1 : k);
  assign stamp_raddr = {idx1_q, slot1};

  lruk_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i ({frame_q, head_old}),
    .wdata_i (now_q),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rd)
  );

  // Scan stage 2: the shared subtract and compare unit
  assign key2  = inf2_q ? stamp_rd : now_q - stamp_rd;
  assign take2 = elig2_q && (!found_q
                             || (inf2_q && !binf_q)
                             || (inf2_q && binf_q && key2 < bkey_q)
                             || (!inf2_q && !binf_q && key2 > bkey_q));

  // Record-access update of the held frame's bookkeeping; an untracked frame
  // starts over at slot 0
  assign cnt_old      = present_q[frame_q] ? meta_rd.cnt : '0;
  assign head_old     = present_q[frame_q] ? meta_rd.head : '0;
  assign meta_wr.cnt  = (cnt_old == CNT_W'(MAX_K)) ? cnt_old : cnt_old + 1'b1;
  assign meta_wr.head = (head_old == SLOT_W'(MAX_K - 1)) ? '0
                                                        : head_old + 1'b1;
  assign hist_we      = (state_q == S_EXEC) && (req_q == REQ_ACCESS) && id_ok && out_free;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    frame_d     = frame_q;
    mark_d      = mark_q;
    present_d   = present_q;
    evict_d     = evict_q;
    evc_d       = evc_q;
    now_d       = now_q;
    nfr_d       = nfr_q;
    depth_d     = depth_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    scan_d      = scan_q;
    v1_d        = (state_q == S_SCAN) && (scan_q < SCAN_W'(NUM_FRAMES));
    idx1_d      = scan_q[ID_W-1:0];
    elig2_d     = v1_q && present_q[idx1_q] && evict_q[idx1_q];
    inf2_d      = inf1;
    idx2_d      = idx1_q;
    found_d     = found_q;
    binf_d      = binf_q;
    bkey_d      = bkey_q;
    best_d      = best_q;
    res         = '{total: '0, vframe: '0, vvalid: 1'b0, status: ST_OK};

    if (cfg_write) begin
      if (paddr[PADDR_W-1] == CFG_HIST_DEPTH) begin
        depth_d = pwdata[DEPTH_W-1:0];
      end else begin
        nfr_d = pwdata[NFR_W-1:0];
      end
    end

    if (take2) begin
      found_d = 1'b1;
      binf_d  = inf2_q;
      bkey_d  = key2;
      best_d  = idx2_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d   = req_e'(s_axis_tuser);
          frame_d = in_frame;
          mark_d  = s_axis_tdata[ID_W];
          if (req_e'(s_axis_tuser) == REQ_EVICT) begin
            scan_d  = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (!id_ok) begin
            res.status = ST_BAD_ID;
          end else begin
            case (req_q)
              REQ_ACCESS: begin
                present_d[frame_q] = 1'b1;
                now_d = (now_q == STAMP_MAX) ? now_q : now_q + 1'b1;
              end
              REQ_SET_MARK: begin
                if (present_q[frame_q]) begin
                  if (mark_q && !evict_q[frame_q]) begin
                    evict_d[frame_q] = 1'b1;
                    evc_d = evc_q + 1'b1;
                  end else if (!mark_q && evict_q[frame_q]) begin
                    evict_d[frame_q] = 1'b0;
                    evc_d = evc_q - 1'b1;
                  end
                end
              end
              REQ_REMOVE: begin
                if (present_q[frame_q]) begin
                  if (!evict_q[frame_q]) begin
                    res.status = ST_PINNED;
                  end else begin
                    present_d[frame_q] = 1'b0;
                    evict_d[frame_q]   = 1'b0;
                    evc_d = evc_q - 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
          res.total   = evc_d;
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        // last frame reaches the compare unit in this cycle
        if (scan_q == SCAN_W'(NUM_FRAMES + 1)) begin
          state_d = S_VICT;
        end
      end
      S_VICT: begin
        if (out_free) begin
          if (!found_q) begin
            res.status = ST_NONE;
          end else begin
            present_d[best_q] = 1'b0;
            evict_d[best_q]   = 1'b0;
            evc_d             = evc_q - 1'b1;
            res.vvalid        = 1'b1;
            res.vframe        = best_q;
          end
          res.total   = evc_d;
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_ACCESS;
      frame_q     <= '0;
      mark_q      <= 1'b0;
      present_q   <= '0;
      evict_q     <= '0;
      evc_q       <= '0;
      now_q       <= '0;
      nfr_q       <= NFR_RESET;
      depth_q     <= DEPTH_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      scan_q      <= '0;
      v1_q        <= 1'b0;
      idx1_q      <= '0;
      elig2_q     <= 1'b0;
      inf2_q      <= 1'b0;
      idx2_q      <= '0;
      found_q     <= 1'b0;
      binf_q      <= 1'b0;
      bkey_q      <= '0;
      best_q      <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      frame_q     <= frame_d;
      mark_q      <= mark_d;
      present_q   <= present_d;
      evict_q     <= evict_d;
      evc_q       <= evc_d;
      now_q       <= now_d;
      nfr_q       <= nfr_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      scan_q      <= scan_d;
      v1_q        <= v1_d;
      idx1_q      <= idx1_d;
      elig2_q     <= elig2_d;
      inf2_q      <= inf2_d;
      idx2_q      <= idx2_d;
      found_q     <= found_d;
      binf_q      <= binf_d;
      bkey_q      <= bkey_d;
      best_q      <= best_d;
    end
  end

`ifndef SYNTH
  // an evictable frame is always a tracked frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (evict_q & ~present_q) == '0)
    else $error("evictable mark on untracked frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   EVC_W'($countones(evict_q)) == evc_q)
    else $error("evictable count out of step with marks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.vvalid) |-> (out_q.status == ST_OK))
    else $error("victim reported with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   now_q >= $past(now_q))
    else $error("timestamp went backward");
`endif

endmodule

/* design/lruk_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module lruk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/tb_lru_k_frame_replacer.sv */
// Self-checking testbench for the LRU-K frame replacer: directed and random requests.
`timescale 1ns / 1ps
module tb_lru_k_frame_replacer;
  import lruk_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_NUM_FRAMES = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_HIST_DEPTH = 3'd4;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_SHOWN   = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;   // frame number, evictable mark, zero pad
  logic [REQ_W-1:0]   s_axis_tuser;   // req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;   // status, victim_valid, victim_frame, evictable_total
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lru_k_frame_replacer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the replacer state
  logic        trk_present [NUM_FRAMES];
  logic        trk_evict   [NUM_FRAMES];
  logic [31:0] trk_stamps  [NUM_FRAMES][MAX_K];  // newest first
  int unsigned trk_count   [NUM_FRAMES];
  logic [31:0] clock_stamp;
  int unsigned evict_total;
  logic [6:0]  cfg_frames;
  logic [2:0]  cfg_depth;

  result_t     pending_outcomes[$];
  int unsigned fail_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t next_outcome(req_e req, logic [ID_W-1:0] id, logic mark);
    result_t     res;
    int unsigned lim, k, best, n, i, g;
    logic        id_ok, found, best_inf, inf;
    logic [31:0] best_key, key;
    res = '0;
    res.status = ST_OK;
    lim = (cfg_frames > NUM_FRAMES) ? NUM_FRAMES : cfg_frames;
    id_ok = id < lim;
    case (req)
      REQ_ACCESS: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else begin
          if (!trk_present[id]) begin
            trk_present[id] = 1'b1;
            trk_evict[id] = 1'b0;
            trk_count[id] = 0;
          end
          for (i = MAX_K - 1; i > 0; i--) trk_stamps[id][i] = trk_stamps[id][i-1];
          trk_stamps[id][0] = clock_stamp;
          if (trk_count[id] < MAX_K) trk_count[id]++;
          // the stamp saturates rather than wrapping
          if (clock_stamp != STAMP_MAX) clock_stamp++;
        end
      end
      REQ_SET_MARK: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (trk_present[id]) begin
          if (mark && !trk_evict[id]) begin
            trk_evict[id] = 1'b1;
            evict_total++;
          end else if (!mark && trk_evict[id]) begin
            trk_evict[id] = 1'b0;
            evict_total--;
          end
        end
      end
      REQ_REMOVE: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (trk_present[id]) begin
          if (!trk_evict[id]) begin
            res.status = ST_PINNED;
          end else begin
            trk_present[id] = 1'b0;
            trk_evict[id] = 1'b0;
            trk_count[id] = 0;
            evict_total--;
          end
        end
      end
      default: begin
        k = (cfg_depth == 0) ? 1 : (cfg_depth > MAX_K) ? MAX_K : cfg_depth;
        found = 1'b0;
        best = 0;
        best_inf = 1'b0;
        best_key = '0;
        for (g = 0; g < NUM_FRAMES; g++) begin
          if (trk_present[g] && trk_evict[g]) begin
            n = trk_count[g];
            inf = n < k;
            // short history: rank by first access; else by backward K-distance
            if (inf) key = (n == 0) ? '0 : trk_stamps[g][n-1];
            else key = clock_stamp - trk_stamps[g][k-1];
            if (!found) begin
              found = 1'b1;
              best = g;
              best_inf = inf;
              best_key = key;
            end else if (inf && !best_inf) begin
              best = g;
              best_inf = 1'b1;
              best_key = key;
            end else if (inf == best_inf && (inf ? key < best_key : key > best_key)) begin
              best = g;
              best_key = key;
            end
          end
        end
        if (!found) begin
          res.status = ST_NONE;
        end else begin
          trk_present[best] = 1'b0;
          trk_evict[best] = 1'b0;
          trk_count[best] = 0;
          evict_total--;
          res.vvalid = 1'b1;
          res.vframe = ID_W'(best);
        end
      end
    endcase
    res.total = EVC_W'(evict_total);
    return res;
  endfunction

  task automatic report_fault(string what, result_t want, result_t got);
    fail_cnt++;
    if (fail_cnt <= MAX_SHOWN) begin
      $display("%s: exp status=%0d vvalid=%0d frame=%0d total=%0d", what,
               want.status, want.vvalid, want.vframe, want.total);
      $display("    got status=%0d vvalid=%0d frame=%0d total=%0d",
               got.status, got.vvalid, got.vframe, got.total);
    end
  endtask

  // Hold off at random, then present one word until the block takes it
  task automatic send_request(req_e req, logic [ID_W-1:0] id, logic mark);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - ID_W - 1){1'b0}}, mark, id};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes = {pending_outcomes, next_outcome(req, id, mark)};
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_NUM_FRAMES) cfg_frames = value[6:0];
    else cfg_depth = value[2:0];
  endtask

  task automatic configure(int unsigned frames, int unsigned depth);
    settle();
    write_reg(ADDR_NUM_FRAMES, PDATA_W'(frames));
    write_reg(ADDR_HIST_DEPTH, PDATA_W'(depth));
  endtask

  task automatic test_request_kinds();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(REQ_EVICT, 6'd0, 1'b0);       // nothing tracked yet
    send_request(REQ_ACCESS, 6'd63, 1'b1);
    send_request(REQ_ACCESS, 6'd0, 1'b0);
    send_request(REQ_ACCESS, 6'd0, 1'b0);
    send_request(REQ_ACCESS, 6'd1, 1'b0);
    send_request(REQ_REMOVE, 6'd1, 1'b0);      // not evictable
    send_request(REQ_SET_MARK, 6'd63, 1'b1);
    send_request(REQ_SET_MARK, 6'd0, 1'b1);
    send_request(REQ_SET_MARK, 6'd1, 1'b1);
    send_request(REQ_SET_MARK, 6'd1, 1'b0);
    send_request(REQ_REMOVE, 6'd5, 1'b1);      // untracked frame
    send_request(REQ_SET_MARK, 6'd5, 1'b1);
    send_request(REQ_EVICT, 6'd63, 1'b1);      // short history wins
    send_request(REQ_REMOVE, 6'd0, 1'b0);
    send_request(REQ_EVICT, 6'd0, 1'b0);       // only a pinned frame left
    settle();
  endtask

  task automatic test_frame_limits();
    configure(0, 2);
    send_request(REQ_ACCESS, 6'd0, 1'b0);      // every id is out of range
    configure(127, 2);
    send_request(REQ_ACCESS, 6'd63, 1'b0);
    send_request(REQ_SET_MARK, 6'd63, 1'b1);
    configure(2, 2);                           // frame 63 stays tracked past the limit
    send_request(REQ_SET_MARK, 6'd1, 1'b1);
    send_request(REQ_REMOVE, 6'd63, 1'b0);
    send_request(REQ_ACCESS, 6'd40, 1'b1);
    send_request(REQ_EVICT, 6'd0, 1'b0);
    send_request(REQ_EVICT, 6'd0, 1'b0);
    send_request(REQ_EVICT, 6'd0, 1'b0);
    settle();
  endtask

  task automatic test_history_depth();
    configure(64, 0);                          // K of zero acts as one
    send_request(REQ_ACCESS, 6'd2, 1'b0);
    send_request(REQ_ACCESS, 6'd3, 1'b0);
    send_request(REQ_ACCESS, 6'd2, 1'b0);
    send_request(REQ_SET_MARK, 6'd2, 1'b1);
    send_request(REQ_SET_MARK, 6'd3, 1'b1);
    send_request(REQ_EVICT, 6'd0, 1'b0);
    configure(64, 7);                          // K clamps to the deepest history
    send_request(REQ_EVICT, 6'd0, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned frames,
                                     int unsigned depth, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned lim, r, i;
    req_e        req;
    logic [5:0]  id;
    logic        mark;
    configure(frames, depth);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      lim = (cfg_frames > NUM_FRAMES) ? NUM_FRAMES : cfg_frames;
      r = $urandom_range(99);
      // mostly a small hot set of valid frames so histories grow deep
      if (lim == 0 || r < 8) id = 6'($urandom_range(63));
      else if (r < 75) id = 6'($urandom_range(((lim < 10) ? lim : 10) - 1));
      else id = 6'($urandom_range(lim - 1));
      r = $urandom_range(99);
      mark = 1'($urandom_range(1));
      if (r < 45) begin
        req = REQ_ACCESS;
      end else if (r < 70) begin
        req = REQ_SET_MARK;
        mark = $urandom_range(99) < 75;
      end else if (r < 80) begin
        req = REQ_REMOVE;
      end else begin
        req = REQ_EVICT;
      end
      send_request(req, id, mark);
      if (i == count / 2) settle();
    end
    settle();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (pending_outcomes.size() == 0) begin
        report_fault("unexpected word", '0, got);
      end else begin
        want = pending_outcomes[0];
        pending_outcomes.delete(0);
        if (got.status !== want.status || got.vvalid !== want.vvalid ||
            got.vframe !== want.vframe || got.total !== want.total) begin
          report_fault("wrong word", want, got);
        end
      end
    end
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    fail_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      trk_present[f] = 1'b0;
      trk_evict[f]   = 1'b0;
      trk_count[f]   = 0;
      for (int s = 0; s < MAX_K; s++) trk_stamps[f][s] = '0;
    end
    clock_stamp = '0;
    evict_total = 0;
    cfg_frames  = NFR_RESET;
    cfg_depth   = DEPTH_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_request_kinds();
    test_frame_limits();
    test_history_depth();
    test_random_traffic(180, 64, 2, 0, 0);
    test_random_traffic(180, 8, 3, 78, 0);
    test_random_traffic(170, 12, 4, 0, 78);
    test_random_traffic(150, 1, 1, 32, 32);
    test_random_traffic(70, 40, 4, 32, 32);

    settle();
    // allow one full victim scan for any stray word
    repeat (NUM_FRAMES + 16) @(posedge clk_i);
    if (fail_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* lru_k_frame_replacer.f */
design/lruk_pkg.sv
design/lruk_ram.sv
design/lru_k_frame_replacer.sv
verif/tb_lru_k_frame_replacer.sv
